### rtl/aabb_pkg.sv
// Shared types and constants for the box pair collision resolver.
`default_nettype none
package aabb_pkg;
  localparam int PosW = 24;
  localparam int HalfW = 20;
  localparam int IdxW = 6;
  localparam int MaskW = 8;

  typedef struct packed {
    logic signed [PosW-1:0]  cx;
    logic signed [PosW-1:0]  cy;
    logic        [HalfW-1:0] hw;
    logic        [HalfW-1:0] hh;
    logic                    dyn;
    logic                    trig;
    logic                    last;
  } box_req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CALC,
    ST_WRITE,
    ST_EMIT
  } eng_state_t;

  // saturate a 26-bit sum to the 24-bit signed range
  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] lo;
    logic signed [PosW+1:0] hi;
    lo = -(26'sd1 <<< (PosW-1));
    hi = (26'sd1 <<< (PosW-1)) - 26'sd1;
    if (v < lo) sat_pos = lo[PosW-1:0];
    else if (v > hi) sat_pos = hi[PosW-1:0];
    else sat_pos = v[PosW-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/aabb_pair_collision_resolver_core.sv
// Top level of the box pair collision resolver.
// Boxes are pushed one request at a time into a four-deep queue; the engine
// stores up to MAX_BOXES of them (extra ones dropped) until a request marked
// last_box. It then checks every pair i<j by a fetch, an overlap and an
// update step, and emits one result per box at one per pop.
// Requests queue up while a set resolves or drains.
`default_nettype none
module aabb_pair_collision_resolver_core
  import aabb_pkg::*;
#(
  parameter int MAX_BOXES = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [PosW-1:0]   center_x,
  input  wire logic signed [PosW-1:0]   center_y,
  input  wire logic [HalfW-1:0]         half_width,
  input  wire logic [HalfW-1:0]         half_height,
  input  wire logic                     is_dynamic,
  input  wire logic                     is_trigger,
  input  wire logic                     last_box,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [IdxW-1:0]               box_index,
  output logic signed [PosW-1:0]        final_x,
  output logic signed [PosW-1:0]        final_y,
  output logic                          stop_x,
  output logic                          stop_y,
  output logic                          grounded,
  output logic [MaskW-1:0]              contact_mask,
  output logic                          last_result
);
  box_req_t in_req, q_req;
  logic q_empty, q_take;

  assign in_req = '{cx: center_x, cy: center_y, hw: half_width, hh: half_height,
                    dyn: is_dynamic, trig: is_trigger, last: last_box};

  aabb_req_fifo u_fifo (
    .clk, .rst, .wr_en(push), .wr_data(in_req), .full,
    .rd_en(q_take), .rd_data(q_req), .empty(q_empty)
  );

  aabb_engine #(.MAX_BOXES(MAX_BOXES)) u_eng (
    .clk, .rst, .req(q_req), .req_valid(!q_empty), .req_take(q_take),
    .box_index, .final_x, .final_y, .stop_x, .stop_y, .grounded,
    .contact_mask, .last_result, .empty, .pop
  );
endmodule
`default_nettype wire

### rtl/aabb_req_fifo.sv
// Short request queue between the front end and the resolver engine.
`default_nettype none
module aabb_req_fifo
  import aabb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_en,
  input  wire box_req_t wr_data,
  output logic          full,
  input  wire logic     rd_en,
  output box_req_t      rd_data,
  output logic          empty
);
  box_req_t   mem [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign rd_data = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wptr] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en && !full) wptr <= wptr + 2'd1;
      if (rd_en && !empty) rptr <= rptr + 2'd1;
      count <= count + {2'b0, wr_en && !full} - {2'b0, rd_en && !empty};
    end
  end
endmodule
`default_nettype wire

### rtl/aabb_engine.sv
// Back end: stores boxes, resolves every pair in order, emits one result per box.
`default_nettype none
module aabb_engine
  import aabb_pkg::*;
#(
  parameter int MAX_BOXES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire box_req_t              req,
  input  wire logic                  req_valid,
  output logic                       req_take,
  output logic [IdxW-1:0]            box_index,
  output logic signed [PosW-1:0]     final_x,
  output logic signed [PosW-1:0]     final_y,
  output logic                       stop_x,
  output logic                       stop_y,
  output logic                       grounded,
  output logic [MaskW-1:0]           contact_mask,
  output logic                       last_result,
  output logic                       empty,
  input  wire logic                  pop
);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  // box store
  logic signed [PosW-1:0]  bx [MAX_BOXES];
  logic signed [PosW-1:0]  by [MAX_BOXES];
  logic        [HalfW-1:0] bhw [MAX_BOXES];
  logic        [HalfW-1:0] bhh [MAX_BOXES];
  logic [MAX_BOXES-1:0] f_dyn, f_trig, f_sx, f_sy, f_gnd;
  logic [MaskW-1:0] cmask [MAX_BOXES];
  logic [CW-1:0] count;

  eng_state_t state, state_next;
  logic [AW-1:0] pi, pj;

  // latched pair operands
  logic signed [PosW-1:0] ax, ay, bxr, byr;
  logic [HalfW-1:0] ahw, ahh, bhwr, bhhr;
  logic adyn, bdyn, atrig, btrig;
  // computed overlaps
  logic signed [PosW+1:0] dx, dy, px, py;

  logic signed [PosW+1:0] dx_c, dy_c, adx, ady, px_c, py_c, p, am, bm;
  logic use_x, sep;

  assign dx_c = $signed({{2{bxr[PosW-1]}}, bxr}) - $signed({{2{ax[PosW-1]}}, ax});
  assign dy_c = $signed({{2{byr[PosW-1]}}, byr}) - $signed({{2{ay[PosW-1]}}, ay});
  assign adx  = dx_c[PosW+1] ? -dx_c : dx_c;
  assign ady  = dy_c[PosW+1] ? -dy_c : dy_c;
  assign px_c = $signed({6'b0, ahw}) + $signed({6'b0, bhwr}) - adx;
  assign py_c = $signed({6'b0, ahh}) + $signed({6'b0, bhhr}) - ady;

  // separation amounts from registered overlaps
  assign use_x = px < py;
  assign p     = use_x ? px : py;
  assign sep   = !atrig && !btrig && (adyn || bdyn);
  always_comb begin
    if (adyn && bdyn) begin
      am = p >>> 1;
      bm = p >>> 1;
    end else begin
      am = adyn ? p : '0;
      bm = bdyn ? p : '0;
    end
    if (use_x ? (dx > 0) : (dy > 0)) am = -am;
    else bm = -bm;
  end

  logic last_pair;
  assign last_pair = ({{(CW-AW){1'b0}}, pj} == count - CW'(1)) &&
                     ({{(CW-AW){1'b0}}, pi} == count - CW'(2));

  // next state
  always_comb begin
    state_next = state;
    req_take   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        req_take = req_valid;
        if (req_valid && req.last) begin
          if (count + CW'(count < CW'(MAX_BOXES) ? 1 : 0) >= CW'(2)) state_next = ST_READ;
          else if (count != '0 || req.last) state_next = ST_EMIT;
        end
      end
      ST_READ:  state_next = ST_CALC;
      ST_CALC:  state_next = ST_WRITE;
      ST_WRITE: state_next = last_pair ? ST_EMIT : ST_READ;
      ST_EMIT: begin
        if (count == '0) state_next = ST_LOAD;
        else if (pop && {{(CW-AW){1'b0}}, pi} == count - CW'(1)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  // result ports
  assign empty        = !(state == ST_EMIT && count != '0);
  assign box_index    = IdxW'(pi);
  assign final_x      = bx[pi];
  assign final_y      = by[pi];
  assign stop_x       = f_sx[pi];
  assign stop_y       = f_sy[pi];
  assign grounded     = f_gnd[pi];
  assign contact_mask = cmask[pi];
  assign last_result  = {{(CW-AW){1'b0}}, pi} == count - CW'(1);

  // operand fetch and overlap registers
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      ax <= bx[pi]; ay <= by[pi]; ahw <= bhw[pi]; ahh <= bhh[pi];
      bxr <= bx[pj]; byr <= by[pj]; bhwr <= bhw[pj]; bhhr <= bhh[pj];
      adyn <= f_dyn[pi]; bdyn <= f_dyn[pj];
      atrig <= f_trig[pi]; btrig <= f_trig[pj];
    end
    if (state == ST_CALC) begin
      dx <= dx_c; dy <= dy_c; px <= px_c; py <= py_c;
    end
  end

  // store, pair walk and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; pi <= '0; pj <= '0;
      f_dyn <= '0; f_trig <= '0; f_sx <= '0; f_sy <= '0; f_gnd <= '0;
      for (int k = 0; k < MAX_BOXES; k++) cmask[k] <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          pi <= '0;
          pj <= AW'(1);
          if (req_valid && count < CW'(MAX_BOXES)) begin
            bx[count[AW-1:0]]  <= req.cx;
            by[count[AW-1:0]]  <= req.cy;
            bhw[count[AW-1:0]] <= req.hw;
            bhh[count[AW-1:0]] <= req.hh;
            f_dyn[count[AW-1:0]]  <= req.dyn;
            f_trig[count[AW-1:0]] <= req.trig;
            cmask[count[AW-1:0]]  <= '0;
            count <= count + CW'(1);
          end
        end
        ST_READ, ST_CALC: ;
        ST_WRITE: begin
          if (px > 0 && py > 0) begin
            if ({{(32-AW){1'b0}}, pj} < 32'd8) cmask[pi][pj[AW-1:0] % MaskW] <= 1'b1;
            if ({{(32-AW){1'b0}}, pi} < 32'd8) cmask[pj][pi[AW-1:0] % MaskW] <= 1'b1;
            if (sep) begin
              if (use_x) begin
                bx[pi] <= sat_pos($signed({{2{ax[PosW-1]}}, ax}) + am);
                bx[pj] <= sat_pos($signed({{2{bxr[PosW-1]}}, bxr}) + bm);
                if (adyn) f_sx[pi] <= 1'b1;
                if (bdyn) f_sx[pj] <= 1'b1;
              end else begin
                by[pi] <= sat_pos($signed({{2{ay[PosW-1]}}, ay}) + am);
                by[pj] <= sat_pos($signed({{2{byr[PosW-1]}}, byr}) + bm);
                if (adyn) f_sy[pi] <= 1'b1;
                if (bdyn) f_sy[pj] <= 1'b1;
                if (dy > 0) begin
                  if (adyn) f_gnd[pi] <= 1'b1;
                end else if (bdyn) f_gnd[pj] <= 1'b1;
              end
            end
          end
          // advance pair
          if ({{(CW-AW){1'b0}}, pj} == count - CW'(1)) begin
            pi <= pi + AW'(1);
            pj <= pi + AW'(2);
          end else begin
            pj <= pj + AW'(1);
          end
          if (last_pair) pi <= '0;
        end
        ST_EMIT: begin
          if (count == '0 || (pop && last_result)) begin
            count <= '0; pi <= '0;
            f_dyn <= '0; f_trig <= '0; f_sx <= '0; f_sy <= '0; f_gnd <= '0;
            for (int k = 0; k < MAX_BOXES; k++) cmask[k] <= '0;
          end else if (pop) begin
            pi <= pi + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/aabb_checker.sv
// Port-level checker for the resolver core, with its bind.
`default_nettype none
module aabb_checker
  import aabb_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            empty,
  input wire logic            pop,
  input wire logic [IdxW-1:0] box_index,
  input wire logic            last_result
);
  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(box_index)) else $error("result changed while held");
  // indices count up within a set
  a_inc: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !last_result ##1 !empty |-> box_index == $past(box_index) + 1'b1)
    else $error("index skipped");
  // the last result closes the set
  a_first: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && last_result |=> empty) else $error("result after last");
  // reset leaves no result
  a_rst: assert property (@(posedge clk) rst |=> empty) else $error("result after reset");
endmodule

bind aabb_pair_collision_resolver_core aabb_checker u_chk (
  .clk, .rst, .empty, .pop, .box_index, .last_result
);
`default_nettype wire
